/* rtl/qcot_pkg.sv */
// Shared types, widths and codes for the quad corner order tracker.
`timescale 1ns / 1ps

package qcot_pkg;

	// Coordinate and arithmetic widths.
	localparam int COORD_W = 12;
	localparam int SUM_W   = COORD_W + 1;
	localparam int DIFF_W  = COORD_W + 2;
	localparam int SQ_W    = 2 * COORD_W;
	localparam int DIST_W  = SQ_W + 1;
	localparam int LOST_W  = 4;
	localparam int LIMIT_W = 26;
	localparam int CMP_W   = (DIST_W > LIMIT_W) ? DIST_W : LIMIT_W;

	// Four corners; pair counter runs over previous slot and new corner.
	localparam int NCORNER = 4;
	localparam int IDX_W   = 2;
	localparam int CNT_W   = 2 * IDX_W + 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NCORNER - 1);

	// Configuration port.
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = LIMIT_W;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LOST    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MATCH_LIMIT = 1'b1;
	localparam logic [LOST_W-1:0]    MAX_LOST_RESET  = LOST_W'(3);
	localparam logic [LIMIT_W-1:0]   LIMIT_RESET     = LIMIT_W'(90000);

	typedef logic [COORD_W-1:0] coord_t;
	typedef logic [SQ_W-1:0]    sq_t;
	typedef logic [DIST_W-1:0]  dist_t;

	typedef enum logic [1:0] {
		STATUS_FRESH = 2'd0,
		STATUS_HELD  = 2'd1,
		STATUS_NONE  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_MATCH,
		S_GEOM,
		S_DONE
	} state_t;

	typedef struct packed {
		logic   quad_found;
		coord_t corner0_x;
		coord_t corner0_y;
		coord_t corner1_x;
		coord_t corner1_y;
		coord_t corner2_x;
		coord_t corner2_y;
		coord_t corner3_x;
		coord_t corner3_y;
	} frame_t;

	typedef struct packed {
		status_t frame_status;
		coord_t  out_tl_x;
		coord_t  out_tl_y;
		coord_t  out_bl_x;
		coord_t  out_bl_y;
		coord_t  out_br_x;
		coord_t  out_br_y;
		coord_t  out_tr_x;
		coord_t  out_tr_y;
	} result_t;

	// Sequencer controls handed to the datapath.
	typedef struct packed {
		logic frame_ready;
		logic issue;
		logic load_out;
	} ctrl_t;

endpackage

/* rtl/qcot_if.sv */
// Valid/ready channel interfaces for frame items and results.
`timescale 1ns / 1ps

interface qcot_frame_if import qcot_pkg::*; ();
	logic   valid;
	logic   ready;
	frame_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface qcot_result_if import qcot_pkg::*; ();
	logic    valid;
	logic    ready;
	result_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

/* rtl/qcot_sqdist.sv */
// Shared squared-distance unit: registered squares, sum on the following cycle.
`timescale 1ns / 1ps

module qcot_sqdist import qcot_pkg::*; (
	input  logic   clk,
	input  logic   en,
	input  coord_t ax,
	input  coord_t ay,
	input  coord_t bx,
	input  coord_t by,
	output dist_t  sq_dist
);

	coord_t dx;
	coord_t dy;
	sq_t    sq_x_s1;
	sq_t    sq_y_s1;

	// Absolute differences along each axis.
	always_comb begin
		dx = (ax > bx) ? (ax - bx) : (bx - ax);
		dy = (ay > by) ? (ay - by) : (by - ay);
	end

	// One multiplier per axis, registered before the sum.
	always_ff @(posedge clk) begin
		if (en) begin
			sq_x_s1 <= SQ_W'(dx) * SQ_W'(dx);
			sq_y_s1 <= SQ_W'(dy) * SQ_W'(dy);
		end
	end

	assign sq_dist = DIST_W'(sq_x_s1) + DIST_W'(sq_y_s1);

endmodule

/* rtl/quad_corner_order_tracker_unit.sv */
// A missed frame goes straight to its result; a fresh quad without tracking takes the
// geometric pass; a tracked match runs up to 16 distance pairs through one shared
// squared-distance unit plus its pipeline stage; a failed row falls back to that pass.
// Throughput: one item at a time; the next is taken once the result is registered.
// Reset (arst_n low, asynchronous): tracking off, lost count and corners zero,
// registers back to 3 missed frames and a limit of 90000.
`timescale 1ns / 1ps

module quad_corner_order_tracker_unit import qcot_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	qcot_frame_if.sink            frame,
	qcot_result_if.source         result,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// Configuration registers.
	logic [LOST_W-1:0]  max_lost_q;
	logic [LIMIT_W-1:0] limit_q;

	// Sequencer and tracking state.
	state_t            state_q, state_d;
	ctrl_t             ctrl;
	logic              tracking_q;
	logic [LOST_W-1:0] lost_q;
	status_t           status_q;
	coord_t            prev_x_q [NCORNER];
	coord_t            prev_y_q [NCORNER];
	coord_t            cx_q [NCORNER];
	coord_t            cy_q [NCORNER];

	// Greedy match state.
	logic [CNT_W-1:0]   cnt_q;
	logic [NCORNER-1:0] used_q;
	logic               v_s1;
	logic [IDX_W-1:0]   i_s1;
	logic [IDX_W-1:0]   j_s1;
	coord_t             bx_s1;
	coord_t             by_s1;
	dist_t              best_d_q;
	coord_t             best_x_q;
	coord_t             best_y_q;
	logic [IDX_W-1:0]   best_j_q;
	logic               found_q;

	// Geometric ordering state.
	logic [IDX_W-1:0]         g_idx_q;
	logic [SUM_W-1:0]         min_s_q;
	logic [SUM_W-1:0]         max_s_q;
	logic signed [DIFF_W-1:0] min_d_q;
	logic signed [DIFF_W-1:0] max_d_q;

	// Output register.
	logic    out_valid_q;
	result_t out_q;

	// Combinational helpers.
	logic                     frame_acc;
	logic [IDX_W-1:0]         rd_idx;
	coord_t                   rd_x;
	coord_t                   rd_y;
	dist_t                    pair_dist;
	logic                     cand;
	dist_t                    nb_d;
	coord_t                   nb_x;
	coord_t                   nb_y;
	logic [IDX_W-1:0]         nb_j;
	logic                     nb_found;
	logic                     row_end;
	logic                     row_fail;
	logic [SUM_W-1:0]         g_s;
	logic signed [DIFF_W-1:0] g_d;
	logic                     g_first;

	assign frame_acc = frame.valid && ctrl.frame_ready;

	// Configuration writes; unknown indexes cannot occur with a one-bit index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_lost_q <= MAX_LOST_RESET;
			limit_q    <= LIMIT_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_MAX_LOST:    max_lost_q <= cfg_data[LOST_W-1:0];
				REG_MATCH_LIMIT: limit_q    <= cfg_data[LIMIT_W-1:0];
				default:         ;
			endcase
		end
	end

	// Next-state logic of the sequencer.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (frame.valid) begin
					if (!frame.payload.quad_found) state_d = S_DONE;
					else if (tracking_q)           state_d = S_MATCH;
					else                           state_d = S_GEOM;
				end
			end
			S_MATCH: begin
				if (row_end) begin
					if (row_fail)              state_d = S_GEOM;
					else if (i_s1 == LAST_IDX) state_d = S_DONE;
				end
			end
			S_GEOM: begin
				if (g_idx_q == LAST_IDX) state_d = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || result.ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		ctrl.frame_ready = (state_q == S_IDLE);
		ctrl.issue       = (state_q == S_MATCH) && !cnt_q[CNT_W-1];
		ctrl.load_out    = (state_q == S_DONE) && (!out_valid_q || result.ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

	// One shared read port on the new corners, used by the match and the geometric pass.
	assign rd_idx = (state_q == S_GEOM) ? g_idx_q : cnt_q[IDX_W-1:0];
	assign rd_x   = cx_q[rd_idx];
	assign rd_y   = cy_q[rd_idx];

	qcot_sqdist u_sqdist (
		.clk     (clk),
		.en      (ctrl.issue),
		.ax      (prev_x_q[cnt_q[2*IDX_W-1:IDX_W]]),
		.ay      (prev_y_q[cnt_q[2*IDX_W-1:IDX_W]]),
		.bx      (rd_x),
		.by      (rd_y),
		.sq_dist (pair_dist)
	);

	// Running nearest unused corner for the current previous slot.
	always_comb begin
		cand     = !used_q[j_s1] && (!found_q || (pair_dist < best_d_q));
		nb_d     = cand ? pair_dist : best_d_q;
		nb_x     = cand ? bx_s1 : best_x_q;
		nb_y     = cand ? by_s1 : best_y_q;
		nb_j     = cand ? j_s1  : best_j_q;
		nb_found = cand || found_q;
		row_end  = (state_q == S_MATCH) && v_s1 && (j_s1 == LAST_IDX);
		row_fail = !nb_found || (CMP_W'(nb_d) > CMP_W'(limit_q));
	end

	// Sum and difference of the corner under the geometric pass.
	always_comb begin
		g_s     = SUM_W'(rd_x) + SUM_W'(rd_y);
		g_d     = $signed(DIFF_W'(rd_y)) - $signed(DIFF_W'(rd_x));
		g_first = (g_idx_q == '0);
	end

	// Pair issue stage: counter, pipeline tags and captured candidate coordinates.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			v_s1  <= 1'b0;
		end else begin
			v_s1 <= ctrl.issue;
			if (frame_acc)       cnt_q <= '0;
			else if (ctrl.issue) cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.issue) begin
			i_s1  <= cnt_q[2*IDX_W-1:IDX_W];
			j_s1  <= cnt_q[IDX_W-1:0];
			bx_s1 <= rd_x;
			by_s1 <= rd_y;
		end
	end

	// Best-so-far registers for the row in progress.
	always_ff @(posedge clk) begin
		if ((state_q == S_MATCH) && v_s1 && (j_s1 != LAST_IDX)) begin
			best_d_q <= nb_d;
			best_x_q <= nb_x;
			best_y_q <= nb_y;
			best_j_q <= nb_j;
		end
	end

	// Geometric extremes; the first corner seeds all four.
	always_ff @(posedge clk) begin
		if (state_q == S_GEOM) begin
			if (g_first || (g_s < min_s_q)) min_s_q <= g_s;
			if (g_first || (g_s > max_s_q)) max_s_q <= g_s;
			if (g_first || (g_d < min_d_q)) min_d_q <= g_d;
			if (g_first || (g_d > max_d_q)) max_d_q <= g_d;
		end
	end

	// Corner capture on acceptance.
	always_ff @(posedge clk) begin
		if (frame_acc) begin
			cx_q[0] <= frame.payload.corner0_x;
			cy_q[0] <= frame.payload.corner0_y;
			cx_q[1] <= frame.payload.corner1_x;
			cy_q[1] <= frame.payload.corner1_y;
			cx_q[2] <= frame.payload.corner2_x;
			cy_q[2] <= frame.payload.corner2_y;
			cx_q[3] <= frame.payload.corner3_x;
			cy_q[3] <= frame.payload.corner3_y;
		end
	end

	// Tracking state, previous corners and match bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tracking_q <= 1'b0;
			lost_q     <= '0;
			status_q   <= STATUS_NONE;
			used_q     <= '0;
			found_q    <= 1'b0;
			g_idx_q    <= '0;
			for (int k = 0; k < NCORNER; k++) begin
				prev_x_q[k] <= '0;
				prev_y_q[k] <= '0;
			end
		end else begin
			case (state_q)
				S_IDLE: begin
					if (frame_acc) begin
						used_q  <= '0;
						found_q <= 1'b0;
						g_idx_q <= '0;
						if (!frame.payload.quad_found) begin
							if (tracking_q && (lost_q < max_lost_q)) begin
								lost_q   <= lost_q + 1'b1;
								status_q <= STATUS_HELD;
							end else begin
								tracking_q <= 1'b0;
								status_q   <= STATUS_NONE;
							end
						end
					end
				end
				S_MATCH: begin
					if (v_s1) begin
						if (j_s1 != LAST_IDX) begin
							found_q <= nb_found;
						end else begin
							found_q <= 1'b0;
							// A rejected row leaves the geometric pass to rewrite all slots.
							if (!row_fail) begin
								prev_x_q[i_s1] <= nb_x;
								prev_y_q[i_s1] <= nb_y;
								used_q[nb_j]   <= 1'b1;
								if (i_s1 == LAST_IDX) begin
									tracking_q <= 1'b1;
									lost_q     <= '0;
									status_q   <= STATUS_FRESH;
								end
							end
						end
					end
				end
				S_GEOM: begin
					g_idx_q <= g_idx_q + 1'b1;
					// Slots: top-left min sum, bottom-left max diff, bottom-right max sum,
					// top-right min diff; strict compares keep the lowest index on ties.
					if (g_first || (g_s < min_s_q)) begin
						prev_x_q[0] <= rd_x;
						prev_y_q[0] <= rd_y;
					end
					if (g_first || (g_d > max_d_q)) begin
						prev_x_q[1] <= rd_x;
						prev_y_q[1] <= rd_y;
					end
					if (g_first || (g_s > max_s_q)) begin
						prev_x_q[2] <= rd_x;
						prev_y_q[2] <= rd_y;
					end
					if (g_first || (g_d < min_d_q)) begin
						prev_x_q[3] <= rd_x;
						prev_y_q[3] <= rd_y;
					end
					if (g_idx_q == LAST_IDX) begin
						tracking_q <= 1'b1;
						lost_q     <= '0;
						status_q   <= STATUS_FRESH;
					end
				end
				S_DONE: ;
				default: ;
			endcase
		end
	end

	// Result register: holds until taken, cleared coordinates when nothing is tracked.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.load_out) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_out) begin
			out_q.frame_status <= status_q;
			out_q.out_tl_x <= (status_q == STATUS_NONE) ? '0 : prev_x_q[0];
			out_q.out_tl_y <= (status_q == STATUS_NONE) ? '0 : prev_y_q[0];
			out_q.out_bl_x <= (status_q == STATUS_NONE) ? '0 : prev_x_q[1];
			out_q.out_bl_y <= (status_q == STATUS_NONE) ? '0 : prev_y_q[1];
			out_q.out_br_x <= (status_q == STATUS_NONE) ? '0 : prev_x_q[2];
			out_q.out_br_y <= (status_q == STATUS_NONE) ? '0 : prev_y_q[2];
			out_q.out_tr_x <= (status_q == STATUS_NONE) ? '0 : prev_x_q[3];
			out_q.out_tr_y <= (status_q == STATUS_NONE) ? '0 : prev_y_q[3];
		end
	end

	assign frame.ready    = ctrl.frame_ready;
	assign result.valid   = out_valid_q;
	assign result.payload = out_q;

	// Each completed row of the greedy match has claimed exactly one new corner.
	a_used_per_row: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MATCH) && v_s1 |-> ($countones(used_q) == int'(i_s1)))
		else $error("used corner count does not match the row under comparison");

	// Matching only ever runs against corners that are being tracked.
	a_match_needs_tracking: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MATCH) |-> tracking_q)
		else $error("greedy match running without tracking");

	// A result with no corners carries all-zero coordinates.
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && (result.payload.frame_status == STATUS_NONE) |->
		(result.payload.out_tl_x == '0) && (result.payload.out_tl_y == '0) &&
		(result.payload.out_bl_x == '0) && (result.payload.out_bl_y == '0) &&
		(result.payload.out_br_x == '0) && (result.payload.out_br_y == '0) &&
		(result.payload.out_tr_x == '0) && (result.payload.out_tr_y == '0))
		else $error("no-corner result carries non-zero coordinates");

endmodule

/* sim/quad_corner_order_tracker_unit_test.sv */
// Self-checking testbench for the quad corner order tracker: directed cases, then random frames.
`timescale 1ns / 1ps

module quad_corner_order_tracker_unit_test import qcot_pkg::*; ();

	localparam int CYCLE_LIMIT = 500000;
	localparam int SETTLE      = 30;
	localparam int IDLE_PCT    = 26;
	localparam int REPORT_MAX  = 10;
	localparam int COORD_MAX   = (1 << COORD_W) - 1;

	typedef logic [NCORNER-1:0][COORD_W-1:0] corner_set_t;
	typedef logic [NCORNER-1:0][IDX_W-1:0]   slot_pick_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_write;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	qcot_frame_if  frame_ch ();
	qcot_result_if result_ch ();

	quad_corner_order_tracker_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.frame     (frame_ch),
		.result    (result_ch),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Mirror of the tracker: registers and tracking state.
	logic [LOST_W-1:0]  lost_limit_q  = MAX_LOST_RESET;
	logic [LIMIT_W-1:0] match_limit_q = LIMIT_RESET;
	corner_set_t        held_x        = '0;
	corner_set_t        held_y        = '0;
	bit                 tracking_q    = 1'b0;
	logic [LOST_W-1:0]  missed_run    = '0;

	result_t pending_results[$];
	bit      steady_flow = 1'b0;
	int      cycle_count = 0;
	int      mismatch_count = 0;
	int      results_seen = 0;
	int      frames_sent = 0;
	int      settings_used = 1;
	int      fresh_count = 0;
	int      held_count = 0;
	int      none_count = 0;
	int      tracked_count = 0;
	int      fallback_count = 0;

	// Geometric order: top-left, bottom-left, bottom-right, top-right; lowest index wins ties.
	function automatic slot_pick_t geometric_pick(corner_set_t cx, corner_set_t cy);
		slot_pick_t pick;
		int s, d, min_s, max_s, min_d, max_d;
		pick = '0;
		min_s = 0;
		max_s = 0;
		min_d = 0;
		max_d = 0;
		for (int i = 0; i < NCORNER; i++) begin
			s = int'(cx[i]) + int'(cy[i]);
			d = int'(cy[i]) - int'(cx[i]);
			if (i == 0 || s < min_s) begin
				min_s = s;
				pick[0] = IDX_W'(i);
			end
			if (i == 0 || d > max_d) begin
				max_d = d;
				pick[1] = IDX_W'(i);
			end
			if (i == 0 || s > max_s) begin
				max_s = s;
				pick[2] = IDX_W'(i);
			end
			if (i == 0 || d < min_d) begin
				min_d = d;
				pick[3] = IDX_W'(i);
			end
		end
		return pick;
	endfunction

	// Greedy nearest match of each held slot to an unused new corner; 0 if any exceeds the limit.
	function automatic bit tracked_pick(corner_set_t cx, corner_set_t cy, output slot_pick_t pick);
		bit [NCORNER-1:0] taken;
		int best;
		longint best_d, pair_d, dx, dy;
		taken = '0;
		pick = '0;
		for (int i = 0; i < NCORNER; i++) begin
			best = -1;
			best_d = 0;
			for (int j = 0; j < NCORNER; j++) begin
				if (!taken[j]) begin
					dx = longint'(held_x[i]) - longint'(cx[j]);
					dy = longint'(held_y[i]) - longint'(cy[j]);
					pair_d = dx * dx + dy * dy;
					if (best < 0 || pair_d < best_d) begin
						best_d = pair_d;
						best = j;
					end
				end
			end
			if (best < 0 || best_d > longint'(match_limit_q))
				return 1'b0;
			pick[i] = IDX_W'(best);
			taken[best] = 1'b1;
		end
		return 1'b1;
	endfunction

	// Advances the mirrored state by one frame and gives the result it must produce.
	function automatic result_t track_corners(frame_t f);
		corner_set_t nx, ny;
		slot_pick_t pick;
		result_t r;
		bit matched;
		nx = {f.corner3_x, f.corner2_x, f.corner1_x, f.corner0_x};
		ny = {f.corner3_y, f.corner2_y, f.corner1_y, f.corner0_y};
		if (f.quad_found) begin
			matched = 1'b0;
			if (tracking_q) begin
				matched = tracked_pick(nx, ny, pick);
				if (matched)
					tracked_count++;
				else
					fallback_count++;
			end
			if (!matched)
				pick = geometric_pick(nx, ny);
			for (int k = 0; k < NCORNER; k++) begin
				held_x[k] = nx[pick[k]];
				held_y[k] = ny[pick[k]];
			end
			tracking_q = 1'b1;
			missed_run = '0;
			r.frame_status = STATUS_FRESH;
			fresh_count++;
		end else if (tracking_q && missed_run < lost_limit_q) begin
			missed_run = missed_run + 1'b1;
			r.frame_status = STATUS_HELD;
			held_count++;
		end else begin
			tracking_q = 1'b0;
			r.frame_status = STATUS_NONE;
			none_count++;
		end
		if (r.frame_status == STATUS_NONE) begin
			r.out_tl_x = '0;
			r.out_tl_y = '0;
			r.out_bl_x = '0;
			r.out_bl_y = '0;
			r.out_br_x = '0;
			r.out_br_y = '0;
			r.out_tr_x = '0;
			r.out_tr_y = '0;
		end else begin
			r.out_tl_x = held_x[0];
			r.out_tl_y = held_y[0];
			r.out_bl_x = held_x[1];
			r.out_bl_y = held_y[1];
			r.out_br_x = held_x[2];
			r.out_br_y = held_y[2];
			r.out_tr_x = held_x[3];
			r.out_tr_y = held_y[3];
		end
		return r;
	endfunction

	function automatic coord_t clamp_coord(int v);
		if (v < 0)
			return '0;
		if (v > COORD_MAX)
			return '1;
		return coord_t'(v);
	endfunction

	// Corner set with element 0 first, clamped to the pixel range.
	function automatic corner_set_t coords4(int a, int b, int c, int d);
		return {clamp_coord(d), clamp_coord(c), clamp_coord(b), clamp_coord(a)};
	endfunction

	function automatic corner_set_t noise_set();
		corner_set_t s;
		for (int k = 0; k < NCORNER; k++)
			s[k] = coord_t'($urandom);
		return s;
	endfunction

	function automatic frame_t pack_frame(logic found, corner_set_t cx, corner_set_t cy);
		frame_t f;
		f.quad_found = found;
		f.corner0_x = cx[0];
		f.corner0_y = cy[0];
		f.corner1_x = cx[1];
		f.corner1_y = cy[1];
		f.corner2_x = cx[2];
		f.corner2_y = cy[2];
		f.corner3_x = cx[3];
		f.corner3_y = cy[3];
		return f;
	endfunction

	function automatic string show_result(result_t r);
		return $sformatf("status=%0d tl=(%0d,%0d) bl=(%0d,%0d) br=(%0d,%0d) tr=(%0d,%0d)",
			r.frame_status, r.out_tl_x, r.out_tl_y, r.out_bl_x, r.out_bl_y,
			r.out_br_x, r.out_br_y, r.out_tr_x, r.out_tr_y);
	endfunction

	// Offers one frame, with random idle cycles first, and records its result once taken.
	task automatic send_frame(input frame_t f);
		while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
			frame_ch.valid <= 1'b0;
			@(posedge clk);
		end
		frame_ch.valid <= 1'b1;
		frame_ch.payload <= f;
		@(posedge clk);
		while (!frame_ch.ready)
			@(posedge clk);
		pending_results.push_back(track_corners(f));
		frames_sent++;
	endtask

	task automatic send_missed();
		send_frame(pack_frame(1'b0, noise_set(), noise_set()));
	endtask

	// Sends the corners in a random input order.
	task automatic send_shuffled(input corner_set_t cx, input corner_set_t cy);
		int perm[NCORNER];
		int j, t;
		corner_set_t px, py;
		for (int i = 0; i < NCORNER; i++)
			perm[i] = i;
		for (int i = NCORNER - 1; i > 0; i--) begin
			j = $urandom_range(i);
			t = perm[i];
			perm[i] = perm[j];
			perm[j] = t;
		end
		for (int i = 0; i < NCORNER; i++) begin
			px[i] = cx[perm[i]];
			py[i] = cy[perm[i]];
		end
		send_frame(pack_frame(1'b1, px, py));
	endtask

	// Holds the sender back until every pending result has been checked.
	task automatic drain_results();
		frame_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Writes both registers while the block is idle; upper data bits beyond the lost limit are junk.
	task automatic configure(input logic [LOST_W-1:0] lost, input logic [LIMIT_W-1:0] limit);
		logic [CFG_DATA_W-1:0] word;
		drain_results();
		word = CFG_DATA_W'($urandom);
		word[LOST_W-1:0] = lost;
		cfg_write <= 1'b1;
		cfg_index <= REG_MAX_LOST;
		cfg_data <= word;
		@(posedge clk);
		cfg_index <= REG_MATCH_LIMIT;
		cfg_data <= limit;
		@(posedge clk);
		cfg_write <= 1'b0;
		lost_limit_q = lost;
		match_limit_q = limit;
		settings_used++;
	endtask

	// A rough quadrilateral somewhere in the image, in top-left, bottom-left, bottom-right,
	// top-right order.
	task automatic new_scene(output corner_set_t sx, output corner_set_t sy);
		int mx, my, w, h;
		mx = $urandom_range(COORD_MAX);
		my = $urandom_range(COORD_MAX);
		w = $urandom_range(2100);
		h = $urandom_range(2100);
		sx = coords4(mx - w, mx - w + int'($urandom_range(60)), mx + w, mx + w);
		sy = coords4(my - h, my + h, my + h - int'($urandom_range(60)), my - h);
	endtask

	// Directed: missed frame before any detection, the extreme corners, holding and losing.
	task automatic test_reset_and_hold();
		send_missed();
		send_frame(pack_frame(1'b1, coords4(COORD_MAX, 0, COORD_MAX, 0),
			coords4(COORD_MAX, 0, 0, COORD_MAX)));
		repeat (int'(MAX_LOST_RESET) + 1) send_missed();
	endtask

	// Directed: ties in the geometric order, with a lost limit of zero.
	task automatic test_geometric_ties();
		configure(LOST_W'(0), LIMIT_RESET);
		send_frame(pack_frame(1'b1, coords4(2048, 2048, 2048, 2048),
			coords4(2048, 2048, 2048, 2048)));
		send_missed();
		send_frame(pack_frame(1'b1, coords4(100, 0, 200, 100), coords4(0, 100, 100, 200)));
	endtask

	// Directed: exact matches under a zero limit, a failed match, and an unlimited match.
	task automatic test_tracking_match();
		configure(LOST_W'(15), LIMIT_W'(0));
		send_frame(pack_frame(1'b1, coords4(300, 1200, 1250, 280), coords4(400, 380, 900, 950)));
		send_frame(pack_frame(1'b1, coords4(1250, 300, 280, 1200), coords4(900, 400, 950, 380)));
		send_frame(pack_frame(1'b1, coords4(1251, 301, 281, 1201), coords4(900, 400, 950, 380)));
		configure(LOST_W'(15), '1);
		send_frame(pack_frame(1'b1, coords4(4000, 100, 3900, 50), coords4(50, 4000, 3900, 120)));
	endtask

	// Directed: the largest lost limit, held frames until tracking drops.
	task automatic test_lost_limit();
		repeat (17) send_missed();
	endtask

	// Random frames: mostly a drifting quad shown in shuffled order, with misses and noise.
	task automatic run_random_phase(input logic [LOST_W-1:0] lost,
			input logic [LIMIT_W-1:0] limit, input int count, input bit steady);
		int issued, run, span;
		int roll;
		corner_set_t sx, sy, nx, ny;
		configure(lost, limit);
		steady_flow = steady;
		new_scene(sx, sy);
		issued = 0;
		while (issued < count) begin
			roll = $urandom_range(99);
			if (roll < 6) begin
				run = $urandom_range(int'(lost) + 2, 1);
				repeat (run) send_missed();
				issued += run;
			end else if (roll < 22) begin
				send_missed();
				issued++;
			end else if (roll < 34) begin
				send_frame(pack_frame(1'b1, noise_set(), noise_set()));
				issued++;
			end else begin
				if ($urandom_range(99) < 8)
					new_scene(sx, sy);
				case ($urandom_range(4))
					0: span = 0;
					1: span = 3;
					2: span = 40;
					3: span = 300;
					default: span = 1500;
				endcase
				for (int k = 0; k < NCORNER; k++) begin
					nx[k] = clamp_coord(int'(sx[k]) + int'($urandom_range(2 * span)) - span);
					ny[k] = clamp_coord(int'(sy[k]) + int'($urandom_range(2 * span)) - span);
				end
				send_shuffled(nx, ny);
				sx = nx;
				sy = ny;
				issued++;
			end
			if ($urandom_range(99) < 2)
				drain_results();
		end
		steady_flow = 1'b0;
	endtask

	// Clock.
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Run-time guard.
	initial begin
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("Timed out after %0d cycles with %0d results pending",
					cycle_count, pending_results.size());
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	// Result side: random back-pressure and a field-by-field check of every transaction.
	initial begin
		result_t want;
		result_t got;
		string bad;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && result_ch.valid && result_ch.ready) begin
				got = result_ch.payload;
				results_seen++;
				if (pending_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_MAX)
						$display("Unexpected result with nothing pending: %s", show_result(got));
				end else begin
					want = pending_results.pop_front();
					bad = "";
					if (got.frame_status !== want.frame_status) bad = {bad, " frame_status"};
					if (got.out_tl_x !== want.out_tl_x) bad = {bad, " out_tl_x"};
					if (got.out_tl_y !== want.out_tl_y) bad = {bad, " out_tl_y"};
					if (got.out_bl_x !== want.out_bl_x) bad = {bad, " out_bl_x"};
					if (got.out_bl_y !== want.out_bl_y) bad = {bad, " out_bl_y"};
					if (got.out_br_x !== want.out_br_x) bad = {bad, " out_br_x"};
					if (got.out_br_y !== want.out_br_y) bad = {bad, " out_br_y"};
					if (got.out_tr_x !== want.out_tr_x) bad = {bad, " out_tr_x"};
					if (got.out_tr_y !== want.out_tr_y) bad = {bad, " out_tr_y"};
					if (bad != "") begin
						mismatch_count++;
						if (mismatch_count <= REPORT_MAX)
							$display("Result %0d wrong in%s: expected %s, got %s",
								results_seen, bad, show_result(want), show_result(got));
					end
				end
			end
			result_ch.ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// Sequence of tests.
	initial begin
		arst_n <= 1'b0;
		frame_ch.valid <= 1'b0;
		frame_ch.payload <= '0;
		cfg_write <= 1'b0;
		cfg_index <= REG_MAX_LOST;
		cfg_data <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_and_hold();
		test_geometric_ties();
		test_tracking_match();
		test_lost_limit();

		run_random_phase(MAX_LOST_RESET, LIMIT_RESET, 300, 1'b0);
		run_random_phase(LOST_W'(0), LIMIT_W'(0), 250, 1'b0);
		run_random_phase(LOST_W'(15), '1, 300, 1'b0);
		run_random_phase(LOST_W'($urandom), LIMIT_W'($urandom_range(5000)), 250, 1'b1);
		run_random_phase(LOST_W'($urandom), LIMIT_W'($urandom), 300, 1'b0);
		run_random_phase(LOST_W'($urandom_range(4, 1)), LIMIT_W'($urandom_range(400000)), 250,
			1'b0);

		drain_results();
		$display("Covered %0d frames under %0d register settings: %0d fresh, %0d held, %0d empty.",
			frames_sent, settings_used, fresh_count, held_count, none_count);
		$display("Tracking kept the order on %0d frames and fell back %0d times; %0d bad results.",
			tracked_count, fallback_count, mismatch_count);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
